// ===== sv/pcmrms_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmrms_pkg
// Shared types and constants for the PCM16 quantiser with RMS level meter.
// ----------------------------------------------------------------------------
package pcmrms_pkg;

	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned PCM_W    = 16;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned SUM_W    = 59;
	localparam int unsigned OP_W     = 32;
	localparam int unsigned PROD_W   = 64;
	localparam int unsigned SUB_W    = 64;
	localparam int unsigned ROOT_W   = 63;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd256;
	localparam logic [OP_W-1:0]    ONE_Q31    = 32'h8000_0000;
	localparam logic [OP_W-1:0]    PCM_SCALE  = 32'd32767;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'd32768;
	localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [SUM_W-1:0]   MEAN_MAX   = 59'd1 << 46;

	typedef struct packed {
		logic [OP_W-1:0]  mul_a;
		logic [OP_W-1:0]  mul_b;
		logic [SUB_W-1:0] sub_a;
		logic [SUB_W-1:0] sub_b;
	} alu_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [SUB_W-1:0]  diff;
		logic              ge;
	} alu_rsp_t;

endpackage

// ===== sv/pcm16_convert_with_rms_level.sv =====
// ----------------------------------------------------------------------------
// pcm16_convert_with_rms_level
// Q1.23 to PCM16 quantiser with buffer RMS level meter.
//
// Input stream: s_tdata carries one signed Q1.23 sample, s_tlast marks the
// final sample of a capture buffer. Output stream: one transaction per input
// transaction, m_tdata = {level, pcm_sample}, m_tuser = level_valid.
// gain (unsigned Q8.8) is written through cfg_valid/cfg_data; cfg_ready is
// always high. Write it only while the block is idle.
// One shared multiplier and one shared subtractor do all the arithmetic
// under a small sequencer, so one sample is taken at a time.
// A plain sample passes through the MUL1, MUL2, MUL3 and ACC states to DONE,
// where its result enters the output register; the sequencer then returns to
// idle to take the next one. A buffer-final sample adds a restoring divide
// (mean square), a set-up state, a bit-serial square root and level scaling
// before the output register. s_tready is high only while the sequencer is idle.
// The output register holds a finished transaction while m_tready is low;
// the next sample is still accepted and its result waits at the end of its
// sequence until the register is free.
// Reset clears the accumulator, the sample count, the output valid and
// restores unity gain; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pcm16_convert_with_rms_level
	import pcmrms_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] pcm_sample, [31:16] level
	output logic        m_tuser,   // level_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // gain
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
	localparam logic [5:0] DIV_LAST = 6'(SUM_W - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_MUL2 = 4'd2;
	localparam logic [3:0] ST_MUL3 = 4'd3;
	localparam logic [3:0] ST_ACC  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_SQI  = 4'd6;
	localparam logic [3:0] ST_SQRT = 4'd7;
	localparam logic [3:0] ST_LVL1 = 4'd8;
	localparam logic [3:0] ST_LVL2 = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0]          state_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic                neg_q;
	logic                last_q;
	logic [PCM_W-1:0]    pcm_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [CNT_W-1:0]    div_cnt_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SUM_W-1:0]    dq_q;
	logic [5:0]          step_q;
	logic [ROOT_W-1:0]   v_q;
	logic [ROOT_W-1:0]   res_q;
	logic [ROOT_W-1:0]   bit_q;
	logic                out_valid_q;
	logic [PCM_W-1:0]    out_pcm_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic                out_lv_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic [SAMPLE_W-1:0] s_mag;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    cnt_next;
	logic [CNT_W:0]      rem_shift;
	logic [OP_W-1:0]     p_clamped;
	logic [14:0]         q_mag;
	logic [SUM_W-1:0]    mean_clamped;
	logic [23:0]         level_raw;
	logic                out_free;

	pcmrms_alu u_alu (
		.clk (clk),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign s_mag     = s_tdata[23] ? (~s_tdata + 24'd1) : s_tdata;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = ~out_valid_q | m_tready;

	assign p_clamped = (alu_rsp.prod > PROD_W'(ONE_Q31)) ? ONE_Q31 : alu_rsp.prod[OP_W-1:0];
	assign q_mag     = alu_rsp.prod[45:31];
	assign sum_add   = {1'b0, sum_q} + (SUM_W + 1)'(alu_rsp.prod[46:0]);
	assign rem_shift = {rem_q, dq_q[SUM_W-1]};
	assign mean_clamped = (dq_q > MEAN_MAX) ? MEAN_MAX : dq_q;
	assign level_raw = alu_rsp.prod[47:24];

	always_comb begin
		sum_next = sum_q;
		cnt_next = cnt_q;
		if (cnt_q < CNT_MAX) begin
			sum_next = (sum_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
			cnt_next = cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_MUL1: begin
				alu_req.mul_a = OP_W'(mag_q);
				alu_req.mul_b = OP_W'(gain_q);
			end
			ST_MUL2: begin
				alu_req.mul_a = p_clamped;
				alu_req.mul_b = PCM_SCALE;
			end
			ST_MUL3: begin
				alu_req.mul_a = OP_W'(mag_q);
				alu_req.mul_b = OP_W'(mag_q);
			end
			ST_DIV: begin
				alu_req.sub_a = SUB_W'(rem_shift);
				alu_req.sub_b = SUB_W'(div_cnt_q);
			end
			ST_SQRT: begin
				alu_req.sub_a = SUB_W'(v_q);
				alu_req.sub_b = SUB_W'(res_q | bit_q);
			end
			ST_LVL1: begin
				alu_req.mul_a = res_q[OP_W-1:0];
				alu_req.mul_b = OP_W'(gain_q);
			end
			default: alu_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_ACC;
				ST_ACC: begin
					if (last_q) begin
						sum_q <= '0;
						cnt_q <= '0;
						state_q <= (cnt_next == '0) ? ST_DONE : ST_DIV;
					end else begin
						sum_q <= sum_next;
						cnt_q <= cnt_next;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_SQI;
					end
				end
				ST_SQI: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (bit_q[0]) begin
						state_q <= ST_LVL1;
					end
				end
				ST_LVL1: state_q <= ST_LVL2;
				ST_LVL2: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q   <= s_mag;
				neg_q   <= s_tdata[23];
				last_q  <= s_tlast;
				level_q <= '0;
			end
			ST_MUL3: begin
				pcm_q <= neg_q ? (16'd0 - PCM_W'(q_mag)) : PCM_W'(q_mag);
			end
			ST_ACC: begin
				dq_q      <= sum_next;
				div_cnt_q <= cnt_next;
				rem_q     <= '0;
				step_q    <= DIV_LAST;
			end
			ST_DIV: begin
				rem_q  <= alu_rsp.ge ? alu_rsp.diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
				dq_q   <= {dq_q[SUM_W-2:0], alu_rsp.ge};
				step_q <= step_q - 6'd1;
			end
			ST_SQI: begin
				v_q   <= {mean_clamped[46:0], 16'd0};
				res_q <= '0;
				bit_q <= ROOT_W'(1) << (ROOT_W - 1);
			end
			ST_SQRT: begin
				if (alu_rsp.ge) begin
					v_q   <= alu_rsp.diff[ROOT_W-1:0];
					res_q <= (res_q >> 1) | bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_LVL2: begin
				level_q <= (level_raw > 24'(LEVEL_MAX)) ? LEVEL_MAX : level_raw[LEVEL_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					out_pcm_q   <= pcm_q;
					out_level_q <= level_q;
					out_lv_q    <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_level_q, out_pcm_q};
	assign m_tuser  = out_lv_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:16] <= LEVEL_MAX))
		else $error("level above full scale");

	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[31:16] == '0))
		else $error("level set on a sample that does not end a buffer");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("sample count beyond its cap");

	a_root_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> ((res_q & bit_q) == '0 && $onehot(bit_q)))
		else $error("square root trial bit overlaps the partial root");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && s_tready))
		else $error("finished transaction not presented");

endmodule

// ===== sv/pcmrms_alu.sv =====
// ----------------------------------------------------------------------------
// pcmrms_alu
// Shared arithmetic unit: registered 32x32 multiplier and a 64-bit
// trial subtractor with compare flag.
// ----------------------------------------------------------------------------
module pcmrms_alu
	import pcmrms_pkg::*;
(
	input  logic     clk,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [PROD_W-1:0] prod_q;
	logic [SUB_W:0]    diff_full;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
	end

	assign diff_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};

	always_comb begin
		rsp.prod = prod_q;
		rsp.diff = diff_full[SUB_W-1:0];
		rsp.ge   = ~diff_full[SUB_W];
	end

endmodule
